### rtl/core/nbk_pkg.sv
// ----------------------------------------------------------------------------
// nbk_pkg
// Types and codes shared by the top-N bid keeper: command and result
// transfers, stored entries, sequencer states and shared-unit controls.
// ----------------------------------------------------------------------------
package nbk_pkg;

	localparam int BID_W  = 31;
	localparam int TAG_W  = 8;
	localparam int UNIT_W = 6;
	localparam int SUM_W  = 36;

	localparam logic       MODE_OFFER     = 1'b0;
	localparam logic       MODE_ADJUDGE   = 1'b1;
	localparam logic [1:0] KIND_REJECTED  = 2'd0;
	localparam logic [1:0] KIND_ACCEPTED  = 2'd1;
	localparam logic [1:0] KIND_SUMMARY   = 2'd2;

	typedef struct packed {
		logic             mode;
		logic [BID_W-1:0] bid;
		logic [TAG_W-1:0] bidder_tag;
	} nbk_cmd_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [TAG_W-1:0]  out_tag;
		logic [BID_W-1:0]  out_bid;
		logic [UNIT_W-1:0] sold_count;
		logic [SUM_W-1:0]  total_amount;
		logic              last_flag;
	} nbk_result_t;

	typedef struct packed {
		logic [BID_W-1:0] bid;
		logic [TAG_W-1:0] tag;
	} nbk_entry_t;

	localparam int ENTRY_W = $bits(nbk_entry_t);

	typedef struct packed {
		logic clr;
		logic acc;
	} nbk_alu_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOW_RD,
		ST_LOW_CMP,
		ST_INS_RD,
		ST_INS_CMP,
		ST_DRN_RD,
		ST_DRN_EMIT,
		ST_SUM
	} nbk_state_t;

endpackage

### rtl/core/nbk_ram.sv
// ----------------------------------------------------------------------------
// nbk_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nbk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/core/nbk_alu.sv
// ----------------------------------------------------------------------------
// nbk_alu
// Shared compare and accumulate unit: one bid compare for the sorted insert and
// the lowest-bid check, one running sum for adjudication.
// ----------------------------------------------------------------------------
module nbk_alu (
	input  logic                        clk,
	input  nbk_pkg::nbk_alu_op_t        op,
	input  logic [nbk_pkg::BID_W-1:0]   a,
	input  logic [nbk_pkg::BID_W-1:0]   b,
	output logic                        gt,
	output logic [nbk_pkg::SUM_W-1:0]   acc
);

	import nbk_pkg::*;

	logic [SUM_W-1:0] acc_q;

	assign gt  = a > b;
	assign acc = acc_q;

	always_ff @(posedge clk) begin
		if (op.clr) begin
			acc_q <= '0;
		end else if (op.acc) begin
			acc_q <= acc_q + SUM_W'(b);
		end
	end

endmodule

### rtl/core/top_n_bid_keeper_core.sv
// ----------------------------------------------------------------------------
// top_n_bid_keeper_core
// Keeps the highest bids for a limited number of units in a sorted store.
// ----------------------------------------------------------------------------
// Offers and adjudications arrive on start while busy is low. Bids sit in a
// circular RAM in ascending order; one compare per held bid walks the new bid
// into place, and each step takes a read state and a compare state because the
// RAM read is registered. When no unit or no space is left, the lowest held bid
// is read and compared first; if the new bid is not above it, the new bid is
// rejected and the item ends, else the lowest bid is rejected and the new bid is
// inserted. With the store empty the new bid is rejected without a read. An
// adjudication of n bids emits n+1 results: the accepted bids in ascending
// order, then the summary in the cycle straight after the last of them. Each
// result is shown for one cycle on result with result_valid; the receiver
// cannot stall and must take it. busy stays high until the final result of an
// item has been shown.
// ----------------------------------------------------------------------------
module top_n_bid_keeper_core #(
	parameter int DEPTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  nbk_pkg::nbk_cmd_t            cmd,
	output logic                         result_valid,
	output nbk_pkg::nbk_result_t         result,
	input  logic                         cfg_we,
	input  logic [nbk_pkg::UNIT_W-1:0]   cfg_wdata
);

	import nbk_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	nbk_state_t        state_q, state_d;
	logic [AW-1:0]     base_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     k_q;
	logic [UNIT_W-1:0] units_q;
	logic [BID_W-1:0]  bid_q;
	logic [TAG_W-1:0]  tag_q;
	nbk_result_t       res_q;
	logic              res_valid_q;

	logic              accept;
	logic              offer_rej;
	logic              ram_we;
	logic              wr_new;
	logic [CW-1:0]     rd_idx;
	logic [CW-1:0]     wr_idx;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     wr_addr;
	logic [AW:0]       rd_sum;
	logic [AW:0]       wr_sum;
	nbk_entry_t        wdata;
	nbk_entry_t        rdata;
	logic [ENTRY_W-1:0] rdata_raw;
	nbk_alu_op_t       alu_op;
	logic              gt;
	logic [SUM_W-1:0]  acc;
	logic              emit;
	nbk_result_t       emit_res;

	assign busy         = (state_q != ST_IDLE) || res_valid_q;
	assign accept       = start && !busy;
	assign result_valid = res_valid_q;
	assign result       = res_q;
	assign rdata        = nbk_entry_t'(rdata_raw);

	assign offer_rej = ((7'(count_q) + 7'd1) > 7'(units_q)) || (count_q == CW'(DEPTH));

	always_comb begin
		rd_sum  = {1'b0, base_q} + (AW+1)'(rd_idx);
		wr_sum  = {1'b0, base_q} + (AW+1)'(wr_idx);
		rd_addr = (rd_sum >= (AW+1)'(DEPTH)) ? AW'(rd_sum - (AW+1)'(DEPTH)) : rd_sum[AW-1:0];
		wr_addr = (wr_sum >= (AW+1)'(DEPTH)) ? AW'(wr_sum - (AW+1)'(DEPTH)) : wr_sum[AW-1:0];
		wdata   = wr_new ? nbk_entry_t'({bid_q, tag_q}) : rdata;
	end

	nbk_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_addr),
		.wdata(wdata),
		.raddr(rd_addr),
		.rdata(rdata_raw)
	);

	nbk_alu u_alu (
		.clk(clk),
		.op (alu_op),
		.a  (bid_q),
		.b  (rdata.bid),
		.gt (gt),
		.acc(acc)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd.mode == MODE_ADJUDGE) begin
						state_d = (count_q == '0) ? ST_SUM : ST_DRN_RD;
					end else if (offer_rej) begin
						state_d = (count_q == '0) ? ST_IDLE : ST_LOW_RD;
					end else begin
						state_d = ST_INS_RD;
					end
				end
			end
			ST_LOW_RD:   state_d = ST_LOW_CMP;
			ST_LOW_CMP:  state_d = gt ? ST_INS_RD : ST_IDLE;
			ST_INS_RD:   state_d = (k_q == '0) ? ST_IDLE : ST_INS_CMP;
			ST_INS_CMP:  state_d = gt ? ST_IDLE : ST_INS_RD;
			ST_DRN_RD:   state_d = ST_DRN_EMIT;
			ST_DRN_EMIT: state_d = ((k_q + CW'(1)) == count_q) ? ST_SUM : ST_DRN_RD;
			ST_SUM:      state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ram_we   = 1'b0;
		wr_new   = 1'b1;
		rd_idx   = '0;
		wr_idx   = k_q;
		alu_op   = '0;
		emit     = 1'b0;
		emit_res = '0;
		case (state_q)
			ST_IDLE: begin
				alu_op.clr = accept;
				if (accept && cmd.mode == MODE_OFFER && offer_rej && count_q == '0) begin
					emit                = 1'b1;
					emit_res.kind       = KIND_REJECTED;
					emit_res.out_tag    = cmd.bidder_tag;
					emit_res.out_bid    = cmd.bid;
					emit_res.last_flag  = 1'b1;
				end
			end
			ST_LOW_RD: begin
				rd_idx = '0;
			end
			ST_LOW_CMP: begin
				emit               = 1'b1;
				emit_res.kind      = KIND_REJECTED;
				emit_res.out_tag   = gt ? rdata.tag : tag_q;
				emit_res.out_bid   = gt ? rdata.bid : bid_q;
				emit_res.last_flag = 1'b1;
			end
			ST_INS_RD: begin
				rd_idx = k_q - CW'(1);
				ram_we = (k_q == '0);
			end
			ST_INS_CMP: begin
				ram_we = 1'b1;
				wr_new = gt;
			end
			ST_DRN_RD: begin
				rd_idx = k_q;
			end
			ST_DRN_EMIT: begin
				alu_op.acc       = 1'b1;
				emit             = 1'b1;
				emit_res.kind    = KIND_ACCEPTED;
				emit_res.out_tag = rdata.tag;
				emit_res.out_bid = rdata.bid;
			end
			ST_SUM: begin
				emit                  = 1'b1;
				emit_res.kind         = KIND_SUMMARY;
				emit_res.sold_count   = UNIT_W'(count_q);
				emit_res.total_amount = acc;
				emit_res.last_flag    = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			base_q      <= '0;
			count_q     <= '0;
			k_q         <= '0;
			units_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= emit;
			if (cfg_we) begin
				units_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						k_q <= (cmd.mode == MODE_ADJUDGE) ? '0 : count_q;
					end
				end
				ST_LOW_CMP: begin
					if (gt) begin
						base_q  <= (base_q == AW'(DEPTH - 1)) ? '0 : base_q + AW'(1);
						count_q <= count_q - CW'(1);
						k_q     <= count_q - CW'(1);
					end
				end
				ST_INS_RD: begin
					if (k_q == '0) begin
						count_q <= count_q + CW'(1);
					end
				end
				ST_INS_CMP: begin
					if (gt) begin
						count_q <= count_q + CW'(1);
					end else begin
						k_q <= k_q - CW'(1);
					end
				end
				ST_DRN_EMIT: begin
					k_q <= k_q + CW'(1);
				end
				ST_SUM: begin
					units_q <= (units_q > UNIT_W'(count_q)) ? units_q - UNIT_W'(count_q) : '0;
					count_q <= '0;
				end
				default: begin
					k_q <= k_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bid_q <= cmd.bid;
			tag_q <= cmd.bidder_tag;
		end
		if (emit) begin
			res_q <= emit_res;
		end
	end

endmodule

### rtl/core/nbk_checker.sv
// ----------------------------------------------------------------------------
// nbk_checker
// Port-level checks on the result stream of the bid keeper, bound to the top.
// ----------------------------------------------------------------------------
module nbk_checker #(
	parameter int DEPTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 busy,
	input  logic                 result_valid,
	input  nbk_pkg::nbk_result_t result
);

	import nbk_pkg::*;

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.kind == KIND_REJECTED || result.kind == KIND_ACCEPTED
			|| result.kind == KIND_SUMMARY))
		else $error("result kind out of range");

	a_last_matches_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.last_flag == (result.kind != KIND_ACCEPTED)))
		else $error("last_flag inconsistent with result kind");

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last_flag |=> !result_valid)
		else $error("result transfer follows the final result of an item");

	a_busy_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("item accepted while a result transfer is shown");

	a_sold_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_SUMMARY |-> result.sold_count <= DEPTH)
		else $error("summary count exceeds store depth");

endmodule

bind top_n_bid_keeper_core nbk_checker #(.DEPTH(DEPTH)) u_nbk_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.busy        (busy),
	.result_valid(result_valid),
	.result      (result)
);
